// ===== rtl/core/b64d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  // Width of the per-message byte counter.
  localparam int CountWidth = 32;
  // Width of the limit compare: wide enough for the counter and the register.
  localparam int CapWidth   = (CountWidth > 32) ? CountWidth : 32;

  localparam int LimitWidth = 32;
  localparam int ByteCountW = 32;
  localparam int CharWidth  = 8;
  localparam int GroupWidth = 24;

  // Output tdata: data_byte, status_code, byte_count, zero fill to bytes.
  localparam int OutFieldsW = 8 + 2 + ByteCountW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  // Symbol classes beyond the 64 alphabet values.
  localparam logic [7:0] SymPad  = 8'd254;
  localparam logic [7:0] SymSkip = 8'd255;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  localparam logic [CountWidth-1:0] CountMask = {CountWidth{1'b1}};
  localparam logic [CapWidth-1:0] LimitReset = CapWidth'({LimitWidth{1'b1}});
  localparam logic [CapWidth-1:0] MaskExt    = CapWidth'(CountMask);
  localparam logic [CapWidth-1:0] CapReset   =
    (LimitReset < MaskExt) ? LimitReset : MaskExt;

  // One queue entry: the results caused by one accepted character.
  typedef struct packed {
    logic [1:0]            nbytes;
    logic [GroupWidth-1:0] group;
    logic                  has_status;
    status_e               status;
    logic [ByteCountW-1:0] count;
  } entry_t;

  function automatic logic [7:0] classify(input logic [7:0] ch);
    logic [7:0] s;
    s = SymSkip;
    if (ch inside {[8'h41:8'h5A]}) begin
      s = ch - 8'h41;
    end else if (ch inside {[8'h61:8'h7A]}) begin
      s = ch - 8'h61 + 8'd26;
    end else if (ch inside {[8'h30:8'h39]}) begin
      s = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      s = 8'd62;
    end else if (ch == 8'h2F) begin
      s = 8'd63;
    end else if (ch == 8'h3D) begin
      s = SymPad;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [b64d_pkg::LimitWidth-1:0]   cfg_wdata_i,
  input  wire logic                              accept_i,
  input  wire logic [b64d_pkg::CharWidth-1:0]    char_i,
  input  wire logic                              eom_i,
  output b64d_pkg::entry_t                       entry_o,
  output logic                                   push_o
);

  logic [b64d_pkg::CapWidth-1:0]   cap_q, cap_d, lim_ext;
  logic [b64d_pkg::GroupWidth-1:0] grp_q, grp_d, grp_shift;
  logic [1:0]                      cnt_q, cnt_d;
  logic [1:0]                      keep_q, keep_d, keep_n;
  logic [b64d_pkg::CountWidth-1:0] count_q, count_d, count_n;
  logic                            drain_q, drain_d;
  logic [7:0]                      sym;
  logic [5:0]                      val;
  logic                            err;
  b64d_pkg::status_e               err_code;
  logic                            ovf;
  logic [b64d_pkg::CapWidth-1:0]   cnt_ext, keep_ext;
  b64d_pkg::entry_t                ent;
  logic                            restart;

  // Limit register holds the effective bound: min(limit, counter range).
  always_comb begin
    lim_ext = b64d_pkg::CapWidth'(cfg_wdata_i);
    cap_d   = cap_q;
    if (cfg_we_i) begin
      cap_d = (lim_ext < b64d_pkg::MaskExt) ? lim_ext : b64d_pkg::MaskExt;
    end
  end

  always_comb begin
    sym       = b64d_pkg::classify(char_i);
    val       = sym[5:0];
    err       = 1'b0;
    err_code  = b64d_pkg::ST_INVALID;
    keep_n    = keep_q;
    grp_shift = grp_q;
    cnt_d     = cnt_q;
    grp_d     = grp_q;
    keep_d    = keep_q;
    count_n   = count_q;
    count_d   = count_q;
    drain_d   = drain_q;
    restart   = 1'b0;
    ent       = '0;
    cnt_ext   = b64d_pkg::CapWidth'(count_q);
    keep_ext  = '0;
    ovf       = 1'b0;

    if (accept_i) begin
      if (drain_q) begin
        restart = eom_i;
      end else begin
        if (sym != b64d_pkg::SymSkip) begin
          if (sym == b64d_pkg::SymPad) begin
            val = '0;
            if (keep_q == 2'd0) begin
              err = 1'b1;
            end else begin
              keep_n = keep_q - 2'd1;
            end
          end else if (keep_q != 2'd3) begin
            err = 1'b1;
          end
          if (!err) begin
            grp_shift = {grp_q[b64d_pkg::GroupWidth-7:0], val};
            keep_ext  = b64d_pkg::CapWidth'(keep_n);
            ovf       = (keep_ext > cap_q) || (cnt_ext > cap_q - keep_ext);
            keep_d    = keep_n;
            grp_d     = grp_shift;
            if (cnt_q == 2'd3) begin
              cnt_d = 2'd0;
              grp_d = '0;
              if (keep_n == 2'd0) begin
                err = 1'b1;
              end else if (ovf) begin
                err      = 1'b1;
                err_code = b64d_pkg::ST_OVERFLOW;
              end else begin
                ent.nbytes = keep_n;
                ent.group  = grp_shift;
                count_n    = count_q + b64d_pkg::CountWidth'(keep_n);
                count_d    = count_n;
              end
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
        end

        if (err) begin
          ent.nbytes     = 2'd0;
          ent.has_status = 1'b1;
          ent.status     = err_code;
          restart        = 1'b1;
        end else if (eom_i) begin
          ent.has_status = 1'b1;
          if (cnt_d != 2'd0) begin
            ent.status = b64d_pkg::ST_INVALID;
          end else begin
            ent.status = b64d_pkg::ST_OK;
            ent.count  = b64d_pkg::ByteCountW'(count_n);
          end
          restart = 1'b1;
        end
      end
    end

    if (restart) begin
      grp_d   = '0;
      cnt_d   = 2'd0;
      keep_d  = 2'd3;
      count_d = '0;
      drain_d = err && !eom_i;
    end
  end

  assign entry_o = ent;
  assign push_o  = accept_i && !drain_q && (ent.has_status || ent.nbytes != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= b64d_pkg::CapReset;
      grp_q   <= '0;
      cnt_q   <= 2'd0;
      keep_q  <= 2'd3;
      count_q <= '0;
      drain_q <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      grp_q   <= grp_d;
      cnt_q   <= cnt_d;
      keep_q  <= keep_d;
      count_q <= count_d;
      drain_q <= drain_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire b64d_pkg::entry_t wdata_i,
  input  wire logic       pop_i,
  output b64d_pkg::entry_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  b64d_pkg::entry_t mem_q [b64d_pkg::FifoDepth];
  logic [b64d_pkg::FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [b64d_pkg::FifoCntW-1:0] fill_q, fill_d;

  localparam logic [b64d_pkg::FifoPtrW-1:0] LastPtr =
    b64d_pkg::FifoPtrW'(b64d_pkg::FifoDepth - 1);
  localparam logic [b64d_pkg::FifoCntW-1:0] FullCnt =
    b64d_pkg::FifoCntW'(b64d_pkg::FifoDepth);

  assign full_o  = (fill_q == FullCnt);
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + b64d_pkg::FifoPtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + b64d_pkg::FifoPtrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + b64d_pkg::FifoCntW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - b64d_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire b64d_pkg::entry_t                head_i,
  input  wire logic                            empty_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [b64d_pkg::OutDataW-1:0]        m_axis_tdata_o,
  output logic                                 m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  logic                            load, take, is_byte, last_in_entry;
  logic [1:0]                      idx_q, idx_d;
  logic [7:0]                      byte_sel;
  logic                            valid_q, valid_d;
  logic                            kind_q;
  logic [7:0]                      byte_q;
  b64d_pkg::status_e               status_q;
  logic [b64d_pkg::ByteCountW-1:0] count_q;
  logic                            last_q;

  assign load = !valid_q || m_axis_tready_i;
  assign take = load && !empty_i;

  always_comb begin
    is_byte = (idx_q < head_i.nbytes);
    case (idx_q)
      2'd0:    byte_sel = head_i.group[23:16];
      2'd1:    byte_sel = head_i.group[15:8];
      default: byte_sel = head_i.group[7:0];
    endcase
    if (is_byte) begin
      last_in_entry = ({1'b0, idx_q} + 3'd1 == {1'b0, head_i.nbytes}) && !head_i.has_status;
    end else begin
      last_in_entry = 1'b1;
    end
    pop_o   = take && last_in_entry;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      idx_d = last_in_entry ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Output register: payload loads only with a new beat.
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q   <= is_byte ? b64d_pkg::KindData : b64d_pkg::KindStatus;
      byte_q   <= is_byte ? byte_sel : 8'd0;
      status_q <= is_byte ? b64d_pkg::ST_OK : head_i.status;
      count_q  <= is_byte ? '0 : head_i.count;
      last_q   <= last_in_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = b64d_pkg::OutDataW'({count_q, status_q, byte_q});

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// Path: a character's results are written into the queue when its beat is
// accepted, then loaded into the output register. Throughput: one character
// per cycle in while the queue is not full; one result per cycle out while
// m_axis_tready_i is high. A character can yield a burst of results; a
// four-entry queue between the decode front and the output stage absorbs them.
// Reset (rst_ni low, asynchronous): decoder state, queue and output clear;
// the output limit returns to all ones.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Output limit register
  input  wire logic                             cfg_we_i,
  input  wire logic [b64d_pkg::LimitWidth-1:0]  cfg_wdata_i,
  // Character stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [b64d_pkg::CharWidth-1:0]   s_axis_tdata_i,  // [7:0] in_char
  input  wire logic                             s_axis_tlast_i,  // end_of_message
  // Result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [7:0] data_byte, [9:8] status_code, [41:10] byte_count, [47:42] zero
  output logic [b64d_pkg::OutDataW-1:0]         m_axis_tdata_o,
  output logic                                  m_axis_tuser_o,  // result_kind
  output logic                                  m_axis_tlast_o   // last_of_run
);

  logic             accept;
  logic             push, pop, full, empty;
  b64d_pkg::entry_t push_entry, head_entry;

  // Front side only stalls when the queue is full; a character that yields
  // nothing still needs a free slot so the check stays one flop deep.
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  // Decode front: classify, pack the group, check pads and limit,
  // and turn each character into at most one queue entry.
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .char_i      (s_axis_tdata_i),
    .eom_i       (s_axis_tlast_i),
    .entry_o     (push_entry),
    .push_o      (push)
  );

  // Hold pending entries so the two sides stall independently.
  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // Output stage: unroll each entry into byte beats, then its status beat, if any.
  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_entry),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // The front never writes into a full queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue overrun");

  // A status beat always closes the run of its character.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == b64d_pkg::KindStatus) |-> m_axis_tlast_o)
    else $error("status beat without tlast");

  // A data beat carries no status and no count.
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == b64d_pkg::KindData)
      |-> (m_axis_tdata_o[b64d_pkg::OutDataW-1:8] == '0))
    else $error("data beat with status fields set");

  // Nothing is popped from an empty queue.
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue underrun");

endmodule
`default_nettype wire
